// ===== sv/word_count_hash_table_top_assert.svh =====
// ----------------------------------------------------------------------------
// word count hash table assertion macros
// concurrent checks, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef WORD_COUNT_HASH_TABLE_TOP_ASSERT_SVH
`define WORD_COUNT_HASH_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define WCT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define WCT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define WCT_ASSERT(name, prop, msg)

`define WCT_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// ===== sv/wct_pkg.sv =====
// ----------------------------------------------------------------------------
// word count hash table package
// shared widths, codes and types
// ----------------------------------------------------------------------------
`default_nettype none

package wct_pkg;

  localparam int TableAw     = 10;
  localparam int TableDepth  = 1 << TableAw;
  localparam int MaxKeyBytes = 8;
  localparam int HashMult    = 19;
  localparam int KeyW        = 64;
  localparam int LenW        = 4;
  localparam int CountW      = 32;

  localparam logic [1:0] ModeInsert = 2'd0;
  localparam logic [1:0] ModeLookup = 2'd1;
  localparam logic [1:0] ModeClear  = 2'd2;

  typedef enum logic [2:0] {
    StNew      = 3'd0,
    StIncr     = 3'd1,
    StFound    = 3'd2,
    StNotFound = 3'd3,
    StFull     = 3'd4,
    StEmptyKey = 3'd5,
    StCleared  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SHash,
    SRead,
    SCmp,
    SDone
  } state_e;

  typedef struct packed {
    logic                valid;
    logic [LenW-1:0]     len;
    logic [KeyW-1:0]     key;
    logic [CountW-1:0]   count;
  } entry_t;

  typedef struct packed {
    logic                we;
    logic [TableAw-1:0]  waddr;
    entry_t              wdata;
    logic [TableAw-1:0]  raddr;
  } store_req_t;

endpackage

`default_nettype wire

// ===== sv/wct_hash.sv =====
// ----------------------------------------------------------------------------
// word count hash unit
// one byte per cycle through a shared multiply-add, h = h*19 + byte
// ----------------------------------------------------------------------------
`default_nettype none

module wct_hash import wct_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [KeyW-1:0]    key_i,
  input  wire logic [LenW-1:0]    len_i,
  output logic                    done_o,
  output logic [TableAw-1:0]      hash_o
);

  logic               busy_q, busy_d;
  logic [LenW-1:0]    cnt_q, cnt_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [TableAw-1:0] h_q, h_d;
  logic [LenW-1:0]    pos;
  logic [2:0]         byte_idx;
  logic [7:0]         cur_byte;
  logic               last;

  always_comb begin
    pos      = len_q - cnt_q - LenW'(1);
    byte_idx = pos[2:0];
    cur_byte = key_q[8*byte_idx +: 8];
    last     = (cnt_q == len_q - LenW'(1));
    h_d      = TableAw'(h_q * TableAw'(HashMult)) + TableAw'(cur_byte);
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    key_d    = key_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      len_d  = len_i;
      key_d  = key_i;
    end else if (busy_q) begin
      cnt_d = cnt_q + LenW'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  assign done_o = busy_q && last;
  assign hash_o = h_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    len_q <= len_d;
    key_q <= key_d;
    if (start_i) begin
      h_q <= '0;
    end else if (busy_q) begin
      h_q <= h_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wct_store.sv =====
// ----------------------------------------------------------------------------
// word count hash table slot store
// one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module wct_store import wct_pkg::*; (
  input  wire logic       clk_i,
  input  wire store_req_t req_i,
  output entry_t          rdata_o
);

  entry_t mem_q [TableDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

`default_nettype wire

// ===== sv/word_count_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// word count hash table top
// open-addressed word-count table with linear probing
// ----------------------------------------------------------------------------
// One item at a time. An item is first hashed (one byte per cycle in the shared
// multiply-add), then each probed slot is read from the slot store and then
// compared and updated, then the result is presented. A clear item and reset
// both start a sweep through all 1024 slots of the slot store, one slot a cycle,
// during which no item is taken.
`default_nettype none

module word_count_hash_table_top import wct_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [1:0]               mode_i,
  input  wire logic [63:0]              key_bytes_i,
  input  wire logic [3:0]               key_length_i,
  input  wire logic signed [31:0]       initial_count_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [2:0]                    status_o,
  output logic signed [31:0]            count_o,
  output logic [9:0]                    slot_o,
  output logic [10:0]                   entries_used_o,
  output logic [31:0]                   collision_total_o,
  output logic [31:0]                   lookup_total_o
);

  `include "word_count_hash_table_top_assert.svh"

  state_e               state_q, state_d;
  logic [1:0]           mode_q, mode_d;
  logic [KeyW-1:0]      key_q, key_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [CountW-1:0]    icnt_q, icnt_d;
  logic [TableAw-1:0]   idx_q, idx_d;
  logic [TableAw-1:0]   start_q, start_d;
  logic [TableAw:0]     steps_q, steps_d;
  status_e              status_q, status_d;
  logic [CountW-1:0]    count_q, count_d;
  logic [TableAw-1:0]   slot_q, slot_d;
  logic [TableAw:0]     occ_q, occ_d;
  logic [31:0]          coll_q, coll_d;
  logic [31:0]          look_q, look_d;
  logic                 clr_cmd_q, clr_cmd_d;

  logic [LenW-1:0]      len_c;
  logic [KeyW-1:0]      key_c;
  logic                 accept;
  logic                 hash_start;
  logic                 hash_done;
  logic [TableAw-1:0]   hash_val;
  store_req_t           req;
  entry_t               rd;
  logic                 match;

  always_comb begin
    len_c = (key_length_i > LenW'(MaxKeyBytes)) ? LenW'(MaxKeyBytes) : key_length_i;
    for (int b = 0; b < 8; b++) begin
      key_c[8*b +: 8] = (LenW'(b) < len_c) ? key_bytes_i[8*b +: 8] : 8'h00;
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign hash_start = accept && (mode_i == ModeInsert || mode_i == ModeLookup)
                      && (len_c != '0);

  wct_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_c),
    .len_i   (len_c),
    .done_o  (hash_done),
    .hash_o  (hash_val)
  );

  wct_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rd)
  );

  assign match = rd.valid && (rd.len == len_q) && (rd.key == key_q);

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    key_d     = key_q;
    len_d     = len_q;
    icnt_d    = icnt_q;
    idx_d     = idx_q;
    start_d   = start_q;
    steps_d   = steps_q;
    status_d  = status_q;
    count_d   = count_q;
    slot_d    = slot_q;
    occ_d     = occ_q;
    coll_d    = coll_q;
    look_d    = look_q;
    clr_cmd_d = clr_cmd_q;
    req       = '0;
    req.raddr = idx_q;
    req.waddr = idx_q;
    case (state_q)
      SClear: begin
        req.we = 1'b1;
        idx_d  = idx_q + TableAw'(1);
        if (idx_q == TableAw'(TableDepth - 1)) begin
          state_d = clr_cmd_q ? SDone : SIdle;
        end
      end
      SIdle: begin
        if (accept) begin
          mode_d   = mode_i;
          key_d    = key_c;
          len_d    = len_c;
          icnt_d   = initial_count_i;
          count_d  = '0;
          slot_d   = '0;
          if (mode_i == ModeClear) begin
            state_d   = SClear;
            idx_d     = '0;
            clr_cmd_d = 1'b1;
            occ_d     = '0;
            coll_d    = '0;
            look_d    = '0;
            status_d  = StCleared;
          end else if (mode_i == ModeInsert || mode_i == ModeLookup) begin
            if (len_c == '0) begin
              state_d  = SDone;
              status_d = StEmptyKey;
            end else begin
              state_d = SHash;
              if (mode_i == ModeLookup) begin
                look_d = look_q + 32'd1;
              end
            end
          end
        end
      end
      SHash: begin
        if (hash_done) begin
          start_d = hash_val;
          idx_d   = hash_val;
          steps_d = '0;
          if (mode_q == ModeInsert && occ_q >= (TableAw+1)'(TableDepth)) begin
            state_d  = SDone;
            status_d = StFull;
            slot_d   = hash_val;
          end else begin
            state_d = SRead;
          end
        end
      end
      SRead: begin
        state_d = SCmp;
      end
      SCmp: begin
        slot_d = idx_q;
        if (!rd.valid) begin
          state_d = SDone;
          if (mode_q == ModeInsert) begin
            req.we          = 1'b1;
            req.wdata.valid = 1'b1;
            req.wdata.len   = len_q;
            req.wdata.key   = key_q;
            req.wdata.count = icnt_q;
            occ_d           = occ_q + (TableAw+1)'(1);
            count_d         = icnt_q;
            status_d        = StNew;
          end else begin
            status_d = StNotFound;
          end
        end else if (match) begin
          state_d = SDone;
          if (mode_q == ModeInsert) begin
            count_d         = (rd.count == 32'h7fff_ffff) ? rd.count : rd.count + 32'd1;
            req.we          = 1'b1;
            req.wdata       = rd;
            req.wdata.count = count_d;
            status_d        = StIncr;
          end else begin
            count_d  = rd.count;
            status_d = StFound;
          end
        end else begin
          coll_d  = coll_q + 32'd1;
          idx_d   = idx_q + TableAw'(1);
          steps_d = steps_q + (TableAw+1)'(1);
          if (steps_q == (TableAw+1)'(TableDepth - 1)) begin
            state_d  = SDone;
            status_d = StNotFound;
            slot_d   = start_q;
          end else begin
            state_d = SRead;
          end
        end
      end
      SDone: begin
        if (out_ready_i) begin
          state_d   = SIdle;
          clr_cmd_d = 1'b0;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SClear;
      idx_q     <= '0;
      occ_q     <= '0;
      coll_q    <= '0;
      look_q    <= '0;
      clr_cmd_q <= 1'b0;
      status_q  <= StCleared;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      occ_q     <= occ_d;
      coll_q    <= coll_d;
      look_q    <= look_d;
      clr_cmd_q <= clr_cmd_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    key_q   <= key_d;
    len_q   <= len_d;
    icnt_q  <= icnt_d;
    start_q <= start_d;
    steps_q <= steps_d;
    count_q <= count_d;
    slot_q  <= slot_d;
  end

  assign in_ready_o        = (state_q == SIdle);
  assign out_valid_o       = (state_q == SDone);
  assign status_o          = status_q;
  assign count_o           = count_q;
  assign slot_o            = slot_q;
  assign entries_used_o    = occ_q;
  assign collision_total_o = coll_q;
  assign lookup_total_o    = look_q;

  `WCT_ASSERT(a_ready_excl_valid, in_ready_o |-> !out_valid_o, "ready while result pending")
  `WCT_ASSERT(a_occ_bound, occ_q <= (TableAw+1)'(TableDepth), "occupancy above depth")
  `WCT_ASSERT(a_clear_zero, (state_q == SClear) |-> (coll_q == '0 && look_q == '0),
              "counters not zero during sweep")
  `WCT_ASSERT(a_hash_in_hash, hash_done |-> (state_q == SHash), "hash done outside hashing")

endmodule

`default_nettype wire
